FILE: rtl/core/pard_pkg.sv
`timescale 1ns / 1ps
package pard_pkg;
    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DISP = 2'd1,
        OP_DONE = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DISP     = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOT_EXEC = 3'd3,
        ST_NONE     = 3'd4
    } t_status;

    localparam int unsigned RESULT_LIMIT = 32;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  task_id;
        logic [63:0] priority_index;
        logic [63:0] chain_mask;
    } t_req;

    typedef struct packed {
        logic [7:0] out_task_id;
        logic [2:0] worker;
        logic [2:0] status;
        logic       last;
    } t_res;
endpackage

FILE: rtl/core/pard_if.sv
`timescale 1ns / 1ps
interface pard_req_if;
    logic             valid;
    logic             ready;
    pard_pkg::t_req   payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface pard_res_if;
    logic             valid;
    logic             ready;
    pard_pkg::t_res   payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface pard_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/precedence_aware_reaction_dispatcher.sv
`timescale 1ns / 1ps
// Dispatcher for prioritised tasks. A dispatch pass visits the pending tasks one by one,
// ending with a scan of the pending store that finds no task left; each step scans the
// pending store for the next lowest index and then the executing set entry by entry.
// Write worker_count only while idle.
module precedence_aware_reaction_dispatcher #(
    parameter int PENDING_DEPTH   = 32,
    parameter int EXECUTING_DEPTH = 16,
    parameter int MAX_WORKERS     = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pard_req_if.sink   s_req,
    pard_cfg_if.sink   s_cfg,
    pard_res_if.source m_res
);
    logic [3:0]     r_worker_count;
    logic           q_valid, q_pop, idle;
    pard_pkg::t_req q_req;

    assign s_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_worker_count <= 4'd1;
        else if (s_cfg.valid && s_cfg.ready)
            r_worker_count <= s_cfg.data;
    end

    pard_front #(.QUEUE_DEPTH(2)) u_front (
        .i_clk, .i_rst_n, .s_req,
        .i_pop(q_pop), .o_valid(q_valid), .o_req(q_req)
    );

    pard_back #(
        .PENDING_DEPTH(PENDING_DEPTH), .EXECUTING_DEPTH(EXECUTING_DEPTH),
        .MAX_WORKERS(MAX_WORKERS)
    ) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_req(q_req), .o_pop(q_pop),
        .i_worker_count(r_worker_count), .o_idle(idle), .m_res
    );

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cfg.valid |-> idle) else $error("config while busy");
endmodule

FILE: rtl/core/pard_front.sv
`timescale 1ns / 1ps
// request queue: accepts requests, drops unused opcodes
module pard_front #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    pard_req_if.sink        s_req,
    input  logic            i_pop,
    output logic            o_valid,
    output pard_pkg::t_req  o_req
);
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    pard_pkg::t_req r_mem [QUEUE_DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;
    logic           push;
    logic           pop;

    assign s_req.ready = (r_cnt < (AW+1)'(QUEUE_DEPTH));
    assign push = s_req.valid && s_req.ready &&
                  (s_req.payload.opcode != pard_pkg::OP_NONE);
    assign o_valid = (r_cnt != '0);
    assign pop = i_pop && o_valid;
    assign o_req = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_mem[r_wp] <= s_req.payload;
                r_wp <= (r_wp == AW'(QUEUE_DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (pop)
                r_rp <= (r_rp == AW'(QUEUE_DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(QUEUE_DEPTH)) else $error("queue overflow");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !o_valid) else $error("pop from empty");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (AW+1)'(QUEUE_DEPTH)) |-> !s_req.ready) else $error("ready when full");
endmodule

FILE: rtl/core/pard_back.sv
`timescale 1ns / 1ps
// executes requests: enqueue and done directly; dispatch scans for minimum, then checks executing set entry by entry
module pard_back #(
    parameter int PENDING_DEPTH   = 32,
    parameter int EXECUTING_DEPTH = 16,
    parameter int MAX_WORKERS     = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  pard_pkg::t_req  i_req,
    output logic            o_pop,
    input  logic [3:0]      i_worker_count,
    output logic            o_idle,
    pard_res_if.source      m_res
);
    localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int EW = (EXECUTING_DEPTH > 1) ? $clog2(EXECUTING_DEPTH) : 1;
    localparam int WW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int RW = $clog2(pard_pkg::RESULT_LIMIT + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_ENQ, S_DONE, S_FIND, S_CHECK, S_DECIDE, S_EMIT, S_END
    } t_state;

    t_state r_state, n_state;

    logic [PENDING_DEPTH-1:0]   r_pv, r_seen;
    logic [7:0]                 r_pid   [PENDING_DEPTH];
    logic [63:0]                r_pidx  [PENDING_DEPTH];
    logic [63:0]                r_pch   [PENDING_DEPTH];
    logic [EXECUTING_DEPTH-1:0] r_ev;
    logic [7:0]                 r_eid   [EXECUTING_DEPTH];
    logic [15:0]                r_elv   [EXECUTING_DEPTH];
    logic [63:0]                r_ech   [EXECUTING_DEPTH];

    logic [WW-1:0]  r_nw;
    logic [63:0]    r_mask;
    logic [RW-1:0]  r_cnt;
    logic [PW:0]    r_pi;
    logic [PW-1:0]  r_best;
    logic           r_found;
    logic [EW:0]    r_ei;
    logic           r_blk;
    logic           r_free_ok;
    logic [EW-1:0]  r_free;
    logic           r_fin;

    pard_pkg::t_res r_out;
    logic           r_ovalid;
    logic           r_hold_valid;
    pard_pkg::t_res r_hold;

    // each dispatched result is held back until the next is dispatched, so the final one can carry last
    logic           r_pend_v;
    pard_pkg::t_res r_pend;

    logic [3:0]     eff_nw;
    logic [WW-1:0]  cur_wk;
    logic [PW-1:0]  pi_idx;
    logic [EW-1:0]  ei_idx;
    logic           cand;

    always_comb begin
        eff_nw = i_worker_count;
        if (eff_nw == 4'd0)
            eff_nw = 4'd1;
        if (32'(eff_nw) > MAX_WORKERS)
            eff_nw = 4'(MAX_WORKERS);
    end

    // next worker wraps before it is used
    assign cur_wk = (32'(r_nw) >= 32'(eff_nw)) ? '0 : r_nw;

    assign pi_idx = r_pi[PW-1:0];
    assign ei_idx = r_ei[EW-1:0];
    assign cand = r_pv[pi_idx] && !r_seen[pi_idx] &&
                  (!r_found || r_pidx[pi_idx] < r_pidx[r_best]);

    // output slot: one result buffered plus output register
    logic out_free;
    assign out_free = !r_hold_valid;
    assign m_res.valid = r_ovalid;
    assign m_res.payload = r_out;
    assign o_idle = (r_state == S_IDLE) && !i_valid;

    logic          emit;
    pard_pkg::t_res emit_res;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (pard_pkg::t_op'(i_req.opcode))
                        pard_pkg::OP_ENQ:  n_state = S_ENQ;
                        pard_pkg::OP_DONE: n_state = S_DONE;
                        default:           n_state = S_FIND;
                    endcase
                end
            end
            S_ENQ, S_DONE: if (out_free) n_state = S_IDLE;
            S_FIND: begin
                if (r_pi == (PW+1)'(PENDING_DEPTH-1) || r_pi >= (PW+1)'(PENDING_DEPTH))
                    n_state = (r_found || cand) ? S_CHECK : S_END;
            end
            S_CHECK: if (r_ei == (EW+1)'(EXECUTING_DEPTH-1)) n_state = S_DECIDE;
            S_DECIDE: n_state = S_EMIT;
            S_EMIT: if (out_free) n_state = S_FIND;
            S_END: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    logic dispatch_ok;
    assign dispatch_ok = !r_blk && ((r_mask & r_pch[r_best]) == '0) && r_free_ok &&
                         (r_cnt < RW'(pard_pkg::RESULT_LIMIT));

    // a found match for done in the executing set
    logic            done_hit;
    logic [EW-1:0]   done_slot;
    always_comb begin
        done_hit = 1'b0;
        done_slot = '0;
        for (int k = EXECUTING_DEPTH-1; k >= 0; k--) begin
            if (r_ev[k] && r_eid[k] == i_req.task_id) begin
                done_hit = 1'b1;
                done_slot = EW'(k);
            end
        end
    end

    logic            pfree_hit;
    logic [PW-1:0]   pfree_slot;
    always_comb begin
        pfree_hit = 1'b0;
        pfree_slot = '0;
        for (int k = PENDING_DEPTH-1; k >= 0; k--) begin
            if (!r_pv[k]) begin
                pfree_hit = 1'b1;
                pfree_slot = PW'(k);
            end
        end
    end

    always_comb begin
        emit = 1'b0;
        emit_res = '0;
        o_pop = 1'b0;
        unique case (r_state)
            S_ENQ: begin
                emit = out_free;
                o_pop = out_free;
                emit_res.out_task_id = i_req.task_id;
                emit_res.status = pfree_hit ? pard_pkg::ST_OK : pard_pkg::ST_FULL;
                emit_res.last = 1'b1;
            end
            S_DONE: begin
                emit = out_free;
                o_pop = out_free;
                emit_res.out_task_id = i_req.task_id;
                emit_res.status = done_hit ? pard_pkg::ST_OK : pard_pkg::ST_NOT_EXEC;
                emit_res.last = 1'b1;
            end
            S_EMIT: begin
                emit = out_free && r_fin && r_pend_v;
                emit_res = r_pend;
            end
            S_END: begin
                o_pop = out_free;
                emit = out_free;
                if (r_pend_v)
                    emit_res = r_pend;
                else
                    emit_res.status = pard_pkg::ST_NONE;
                emit_res.last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pv         <= '0;
            r_ev         <= '0;
            r_nw         <= '0;
            r_ovalid     <= 1'b0;
            r_hold_valid <= 1'b0;
            r_pend_v     <= 1'b0;
            r_cnt        <= '0;
            r_found      <= 1'b0;
        end else begin
            r_state <= n_state;
            // output register with a one-entry skid
            if (r_ovalid && !m_res.ready) begin
                if (emit && !r_hold_valid) begin
                    r_hold_valid <= 1'b1;
                    r_hold <= emit_res;
                end
            end else begin
                if (r_hold_valid) begin
                    r_out <= r_hold;
                    r_ovalid <= 1'b1;
                    r_hold_valid <= 1'b0;
                    if (emit) begin
                        r_hold <= emit_res;
                        r_hold_valid <= 1'b1;
                    end
                end else begin
                    r_ovalid <= emit;
                    r_out <= emit_res;
                end
            end
            if (r_state == S_END && out_free && r_pend_v) begin
                r_pend_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_pi    <= '0;
                    r_found <= 1'b0;
                    r_seen  <= '0;
                    r_mask  <= '0;
                    r_cnt   <= '0;
                end
                S_ENQ: if (out_free && pfree_hit) begin
                    r_pv[pfree_slot]   <= 1'b1;
                    r_pid[pfree_slot]  <= i_req.task_id;
                    r_pidx[pfree_slot] <= i_req.priority_index;
                    r_pch[pfree_slot]  <= i_req.chain_mask;
                end
                S_DONE: if (out_free && done_hit) r_ev[done_slot] <= 1'b0;
                S_FIND: begin
                    if (cand) begin
                        r_best  <= pi_idx;
                        r_found <= 1'b1;
                    end
                    r_pi <= r_pi + 1'b1;
                    r_ei <= '0;
                    r_blk <= 1'b0;
                    r_free_ok <= 1'b0;
                end
                S_CHECK: begin
                    if (r_ev[ei_idx] && r_elv[ei_idx] < r_pidx[r_best][15:0] &&
                        (r_ech[ei_idx] & r_pch[r_best]) != '0)
                        r_blk <= 1'b1;
                    if (!r_ev[ei_idx] && !r_free_ok) begin
                        r_free_ok <= 1'b1;
                        r_free <= ei_idx;
                    end
                    r_ei <= r_ei + 1'b1;
                end
                S_DECIDE: begin
                    r_seen[r_best] <= 1'b1;
                    r_fin <= dispatch_ok;
                    if (!dispatch_ok)
                        r_mask <= r_mask | r_pch[r_best];
                end
                S_EMIT: if (out_free) begin
                    r_pi <= '0;
                    r_found <= 1'b0;
                    if (r_fin) begin
                        r_ev[r_free]  <= 1'b1;
                        r_eid[r_free] <= r_pid[r_best];
                        r_elv[r_free] <= r_pidx[r_best][15:0];
                        r_ech[r_free] <= r_pch[r_best];
                        r_pv[r_best]  <= 1'b0;
                        r_cnt <= r_cnt + 1'b1;
                        r_nw <= (32'(cur_wk) + 1 >= 32'(eff_nw)) ? '0 : cur_wk + 1'b1;
                        r_pend_v <= 1'b1;
                        r_pend.out_task_id <= r_pid[r_best];
                        r_pend.worker <= 3'(cur_wk);
                        r_pend.status <= pard_pkg::ST_DISP;
                        r_pend.last <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    a_disp_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free && r_fin) |=> r_ev[$past(r_free)])
        else $error("dispatch slot not marked");
    a_cnt_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= RW'(pard_pkg::RESULT_LIMIT)) else $error("dispatch count overflow");
    a_nw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_nw) < MAX_WORKERS) else $error("worker out of range");
endmodule

FILE: sim/tb_precedence_aware_reaction_dispatcher.sv
`timescale 1ns / 1ps
module tb_precedence_aware_reaction_dispatcher;
    localparam int PEND_N = 32;
    localparam int EXEC_N = 16;
    localparam int WORKERS_MAX = 8;
    localparam int DISPATCH_LIMIT = 32;
    localparam longint CYCLE_LIMIT = 2000000;

    class dispatch_scoreboard;
        bit          pend_valid[PEND_N];
        logic [7:0]  pend_id[PEND_N];
        logic [63:0] pend_index[PEND_N];
        logic [63:0] pend_chain[PEND_N];
        bit          exec_valid[EXEC_N];
        logic [7:0]  exec_id[EXEC_N];
        logic [15:0] exec_level[EXEC_N];
        logic [63:0] exec_chain[EXEC_N];
        int          next_worker;
        logic [3:0]  worker_count;
        pard_pkg::t_res expected_results[$];
        int          errors;

        function new();
            next_worker = 0;
            worker_count = 4'd1;
            errors = 0;
            foreach (pend_valid[i]) pend_valid[i] = 0;
            foreach (exec_valid[i]) exec_valid[i] = 0;
        endfunction

        function void push_result(logic [7:0] id, int wk, pard_pkg::t_status st, bit lst);
            pard_pkg::t_res r;
            r.out_task_id = id;
            r.worker = wk[2:0];
            r.status = st;
            r.last = lst;
            expected_results.push_back(r);
        endfunction

        function bit exec_blocks(logic [15:0] level, logic [63:0] chain);
            for (int i = 0; i < EXEC_N; i++)
                if (exec_valid[i] && exec_level[i] < level && (exec_chain[i] & chain) != 0)
                    return 1;
            return 0;
        endfunction

        function void run_dispatch();
            bit seen[PEND_N];
            logic [63:0] mask;
            int nw;
            int count;
            int best;
            int slot;
            bit held;
            mask = 0;
            count = 0;
            nw = (worker_count == 0) ? 1 : (worker_count > WORKERS_MAX) ? WORKERS_MAX
                : worker_count;
            foreach (seen[i]) seen[i] = 0;
            forever begin
                best = -1;
                for (int i = 0; i < PEND_N; i++)
                    if (pend_valid[i] && !seen[i] &&
                        (best < 0 || pend_index[i] < pend_index[best]))
                        best = i;
                if (best < 0) break;
                seen[best] = 1;
                held = (mask & pend_chain[best]) != 0 ||
                       exec_blocks(pend_index[best][15:0], pend_chain[best]);
                slot = -1;
                for (int i = 0; i < EXEC_N; i++)
                    if (!exec_valid[i] && slot < 0) slot = i;
                if (!held && slot >= 0 && count < DISPATCH_LIMIT) begin
                    if (next_worker >= nw) next_worker = 0;
                    push_result(pend_id[best], next_worker, pard_pkg::ST_DISP, 0);
                    count++;
                    next_worker++;
                    if (next_worker >= nw) next_worker = 0;
                    exec_valid[slot] = 1;
                    exec_id[slot] = pend_id[best];
                    exec_level[slot] = pend_index[best][15:0];
                    exec_chain[slot] = pend_chain[best];
                    pend_valid[best] = 0;
                end else begin
                    mask |= pend_chain[best];
                end
            end
            if (count == 0) push_result(8'd0, 0, pard_pkg::ST_NONE, 1);
            else expected_results[$].last = 1;
        endfunction

        function void note_request(pard_pkg::t_req q);
            int slot;
            case (q.opcode)
                pard_pkg::OP_ENQ: begin
                    slot = -1;
                    for (int i = 0; i < PEND_N; i++)
                        if (!pend_valid[i] && slot < 0) slot = i;
                    if (slot >= 0) begin
                        pend_valid[slot] = 1;
                        pend_id[slot] = q.task_id;
                        pend_index[slot] = q.priority_index;
                        pend_chain[slot] = q.chain_mask;
                        push_result(q.task_id, 0, pard_pkg::ST_OK, 1);
                    end else begin
                        push_result(q.task_id, 0, pard_pkg::ST_FULL, 1);
                    end
                end
                pard_pkg::OP_DISP: run_dispatch();
                pard_pkg::OP_DONE: begin
                    slot = -1;
                    for (int i = 0; i < EXEC_N; i++)
                        if (exec_valid[i] && exec_id[i] == q.task_id && slot < 0) slot = i;
                    if (slot >= 0) begin
                        exec_valid[slot] = 0;
                        push_result(q.task_id, 0, pard_pkg::ST_OK, 1);
                    end else begin
                        push_result(q.task_id, 0, pard_pkg::ST_NOT_EXEC, 1);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(pard_pkg::t_res got);
            pard_pkg::t_res want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.out_task_id !== want.out_task_id)
                $display("%0t: task id expected %0d actual %0d", $time,
                         want.out_task_id, got.out_task_id);
            if (got.worker !== want.worker)
                $display("%0t: worker expected %0d actual %0d", $time, want.worker, got.worker);
            if (got.status !== want.status)
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            if (got.last !== want.last)
                $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            if (got !== want) errors++;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    pard_req_if s_req();
    pard_cfg_if s_cfg();
    pard_res_if m_res();

    precedence_aware_reaction_dispatcher i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_req   (s_req.sink),
        .s_cfg   (s_cfg.sink),
        .m_res   (m_res.source)
    );

    dispatch_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_off;
    longint cycles;
    logic [7:0] recent_ids[$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver with random stall and a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_res.ready <= 0;
        end else begin
            if (m_res.valid && m_res.ready) sb.check_result(m_res.payload);
            m_res.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_request(pard_pkg::t_op op, logic [7:0] id, logic [63:0] idx,
                                logic [63:0] chain);
        pard_pkg::t_req q;
        while ($urandom_range(99) < send_idle_pct) begin
            s_req.valid <= 0;
            @(posedge i_clk);
        end
        q.opcode = op;
        q.task_id = id;
        q.priority_index = idx;
        q.chain_mask = chain;
        s_req.valid <= 1;
        s_req.payload <= q;
        do @(posedge i_clk); while (!s_req.ready);
        sb.note_request(q);
    endtask

    task automatic wait_drained();
        s_req.valid <= 0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_workers(logic [3:0] n);
        wait_drained();
        s_cfg.valid <= 1;
        s_cfg.data <= n;
        do @(posedge i_clk); while (!s_cfg.ready);
        sb.worker_count = n;
        s_cfg.valid <= 0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_chain();
        case ($urandom_range(3))
            0: return 64'd1 << $urandom_range(63);
            1: return (64'd1 << $urandom_range(7)) | (64'd1 << $urandom_range(7));
            2: return 64'd0;
            default: return rand64();
        endcase
    endfunction

    function automatic logic [63:0] rand_index();
        logic [63:0] v;
        v = rand64();
        if ($urandom_range(1)) v[63:20] = '0;
        if ($urandom_range(1)) v[15:0] = 16'($urandom_range(7));
        return v;
    endfunction

    task automatic random_item();
        int r;
        logic [7:0] id;
        r = $urandom_range(99);
        if (r < 50) begin
            id = $urandom_range(1) ? 8'($urandom_range(31)) : 8'($urandom);
            recent_ids.push_back(id);
            if (recent_ids.size() > 40) void'(recent_ids.pop_front());
            send_request(pard_pkg::OP_ENQ, id, rand_index(), rand_chain());
        end else if (r < 70) begin
            send_request(pard_pkg::OP_DISP, 8'($urandom), rand64(), rand64());
        end else if (r < 95) begin
            id = (recent_ids.size() > 0 && $urandom_range(3) != 0)
                ? recent_ids[$urandom_range(recent_ids.size() - 1)] : 8'($urandom);
            send_request(pard_pkg::OP_DONE, id, rand64(), rand64());
        end else begin
            send_request(pard_pkg::OP_NONE, 8'($urandom), rand64(), rand64());
        end
    endtask

    initial begin
        i_clk = 0;
        sb = new();
        cycles = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 0;
        s_req.valid = 0;
        s_req.payload = '0;
        s_cfg.valid = 0;
        s_cfg.data = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, chains, levels, full store, done miss, opcode 3
        send_request(pard_pkg::OP_DISP, 8'd0, 64'd0, 64'd0);
        send_request(pard_pkg::OP_DONE, 8'hff, 64'd0, 64'd0);
        send_request(pard_pkg::OP_ENQ, 8'hff, 64'hffff_ffff_ffff_ffff,
                     64'hffff_ffff_ffff_ffff);
        send_request(pard_pkg::OP_ENQ, 8'd0, 64'd0, 64'd0);
        send_request(pard_pkg::OP_ENQ, 8'd1, 64'h10_0005, 64'h1);
        send_request(pard_pkg::OP_ENQ, 8'd2, 64'h10_0005, 64'h1);
        send_request(pard_pkg::OP_ENQ, 8'd3, 64'h20_0001, 64'h2);
        send_request(pard_pkg::OP_NONE, 8'haa, 64'hffff_ffff_ffff_ffff,
                     64'hffff_ffff_ffff_ffff);
        send_request(pard_pkg::OP_DISP, 8'd0, 64'd0, 64'd0);
        send_request(pard_pkg::OP_ENQ, 8'd4, 64'h9, 64'h2);
        send_request(pard_pkg::OP_DISP, 8'd0, 64'd0, 64'd0);
        send_request(pard_pkg::OP_DONE, 8'd1, 64'd0, 64'd0);
        send_request(pard_pkg::OP_DONE, 8'd1, 64'd0, 64'd0);
        send_request(pard_pkg::OP_DISP, 8'd0, 64'd0, 64'd0);
        for (int i = 0; i < 34; i++)
            send_request(pard_pkg::OP_ENQ, 8'(i + 10), 64'(i), 64'd0);
        write_workers(4'd8);
        send_request(pard_pkg::OP_DISP, 8'd0, 64'd0, 64'd0);
        for (int i = 0; i < 20; i++)
            send_request(pard_pkg::OP_DONE, 8'(i + 10), 64'd0, 64'd0);
        send_request(pard_pkg::OP_DISP, 8'd0, 64'd0, 64'd0);
        write_workers(4'd0);
        send_request(pard_pkg::OP_DISP, 8'd0, 64'd0, 64'd0);
        write_workers(4'd15);
        send_request(pard_pkg::OP_DISP, 8'd0, 64'd0, 64'd0);

        // random phases with different idling and worker settings
        for (int ph = 0; ph < 6; ph++) begin
            write_workers(ph == 5 ? 4'd1 : 4'($urandom_range(15)));
            for (int i = 0; i < 16; i++)
                send_request(pard_pkg::OP_DONE, 8'($urandom_range(31)), 0, 0);
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 61; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 61; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            if (ph == 4) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (3000) @(posedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int i = 0; i < 35; i++) random_item();
            if (ph == 2) wait_drained();
        end

        wait_drained();
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
